### hw/rtl/dec_pkg.sv
// Shared types and codes for the deletion-only edit cost row block.
`default_nettype none

package dec_pkg;

  localparam logic [1:0] OP_LOAD_WINDOW  = 2'd0;
  localparam logic [1:0] OP_LOAD_PATTERN = 2'd1;
  localparam logic [1:0] OP_COMPUTE      = 2'd2;

  localparam int unsigned SymW  = 8;
  localparam int unsigned CostW = 6;

  localparam logic [CostW-1:0] MaxDelReset = 6'd32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_EMIT
  } dec_state_e;

  typedef struct packed {
    logic load_win;
    logic load_pat;
    logic start;
    logic step;
    logic emit;
    logic finish;
  } dec_cmd_t;

  typedef struct packed {
    logic pat_empty;
    logic step_last;
    logic emit_last;
    logic out_free;
  } dec_stat_t;

endpackage

`default_nettype wire

### hw/rtl/dec_ctrl.sv
// Controller state machine that sequences loads, row updates and result output.
`default_nettype none

module dec_ctrl
  import dec_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  output logic       in_ready_o,
  input  dec_stat_t  stat_i,
  output dec_cmd_t   cmd_o
);

  dec_state_e state_q, state_d;
  logic       in_fire;

  assign in_fire = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_op_i == OP_COMPUTE)) begin
          state_d = stat_i.pat_empty ? ST_EMIT : ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat_i.step_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free && stat_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_fire) begin
          unique case (in_op_i)
            OP_LOAD_WINDOW:  cmd_o.load_win = 1'b1;
            OP_LOAD_PATTERN: cmd_o.load_pat = 1'b1;
            OP_COMPUTE:      cmd_o.start    = 1'b1;
            default:         cmd_o          = '0;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit   = 1'b1;
          cmd_o.finish = stat_i.emit_last;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dec_datapath.sv
// Datapath with symbol stores, counts, the cost row cells and the result register.
`default_nettype none

module dec_datapath
  import dec_pkg::*;
#(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [SymW-1:0]  sym_i,
  input  logic             cfg_we_i,
  input  logic [CostW-1:0] cfg_data_i,
  input  dec_cmd_t         cmd_i,
  output dec_stat_t        stat_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic [5:0]       out_offset_o,
  output logic [CostW-1:0] out_del_o,
  output logic             out_reach_o,
  output logic             out_last_o
);

  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [SymW-1:0]  win_q [MAX_LEN];
  logic [SymW-1:0]  pat_q [MAX_LEN];
  logic [CW-1:0]    wcnt_q;
  logic [CW-1:0]    pcnt_q;
  logic [CW-1:0]    u_q;
  logic [CW-1:0]    o_q;
  logic [CW-1:0]    mlen;
  logic [CostW-1:0] maxdel_q;
  logic [CostW-1:0] cost_q [MAX_LEN+1];
  logic [MAX_LEN:0] ok_q;
  logic [CostW-1:0] nc [MAX_LEN+1];
  logic [MAX_LEN:0] nok;
  logic [SymW-1:0]  pat_sym;
  logic             out_valid_q;
  logic [5:0]       off_q;
  logic [CostW-1:0] del_q;
  logic             reach_q;
  logic             last_q;

  assign mlen    = (pcnt_q < wcnt_q) ? pcnt_q : wcnt_q;
  assign pat_sym = pat_q[u_q[IW-1:0]];

  assign stat_o.pat_empty = (pcnt_q == '0);
  assign stat_o.step_last = ((u_q + CW'(1)) == pcnt_q);
  assign stat_o.emit_last = (o_q == mlen);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxdel_q <= MaxDelReset;
    end else if (cfg_we_i) begin
      maxdel_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcnt_q <= '0;
      pcnt_q <= '0;
      u_q    <= '0;
      o_q    <= '0;
    end else begin
      if (cmd_i.load_win && (wcnt_q < CW'(MAX_LEN))) begin
        wcnt_q <= wcnt_q + CW'(1);
      end
      if (cmd_i.load_pat && (pcnt_q < CW'(MAX_LEN))) begin
        pcnt_q <= pcnt_q + CW'(1);
      end
      if (cmd_i.start) begin
        u_q <= '0;
        o_q <= '0;
      end
      if (cmd_i.step) begin
        u_q <= u_q + CW'(1);
      end
      if (cmd_i.emit) begin
        o_q <= o_q + CW'(1);
      end
      if (cmd_i.finish) begin
        wcnt_q <= '0;
        pcnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_win && (wcnt_q < CW'(MAX_LEN))) begin
      win_q[wcnt_q[IW-1:0]] <= sym_i;
    end
    if (cmd_i.load_pat && (pcnt_q < CW'(MAX_LEN))) begin
      pat_q[pcnt_q[IW-1:0]] <= sym_i;
    end
  end

  for (genvar g = 0; g <= MAX_LEN; g++) begin : g_cell
    logic       act;
    logic       del_ok;
    logic [6:0] inc;

    always_comb begin
      inc    = {1'b0, cost_q[g]} + 7'd1;
      act    = (CW'(g) <= (u_q + CW'(1))) && (CW'(g) <= mlen);
      del_ok = ok_q[g] && (inc <= {1'b0, maxdel_q});
    end

    if (g == 0) begin : g_first
      always_comb begin
        nok[g] = act && del_ok;
        nc[g]  = inc[CostW-1:0];
      end
    end else begin : g_rest
      logic mat_ok;
      always_comb begin
        mat_ok = ok_q[g-1] && (pat_sym == win_q[g-1]);
        nok[g] = act && (mat_ok || del_ok);
        if (mat_ok && (!del_ok || (cost_q[g-1] <= inc[CostW-1:0]))) begin
          nc[g] = cost_q[g-1];
        end else begin
          nc[g] = inc[CostW-1:0];
        end
      end
    end
  end

  // The row shifts down one entry per emitted result, so entry zero is the current offset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      ok_q      <= {{MAX_LEN{1'b0}}, 1'b1};
      cost_q[0] <= '0;
    end else if (cmd_i.step) begin
      ok_q <= nok;
      for (int i = 0; i <= MAX_LEN; i++) begin
        cost_q[i] <= nc[i];
      end
    end else if (cmd_i.emit) begin
      ok_q <= {1'b0, ok_q[MAX_LEN:1]};
      for (int i = 0; i < MAX_LEN; i++) begin
        cost_q[i] <= cost_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      off_q   <= 6'(o_q);
      del_q   <= ok_q[0] ? cost_q[0] : '0;
      reach_q <= ok_q[0];
      last_q  <= (o_q == mlen);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_offset_o = off_q;
  assign out_del_o    = del_q;
  assign out_reach_o  = reach_q;
  assign out_last_o   = last_q;

endmodule

`default_nettype wire

### hw/rtl/deletion_edit_cost_row.sv
// Top level of the deletion-only edit cost row block.
// A load transaction (window or pattern symbol) appends one symbol unless that store is full.
// A compute transaction resets the row on its start, then performs P row updates, one per
// pattern symbol, through the single row-update stage whose cells all work in parallel,
// followed by min(P, W) + 1 results, one per offset, paced by the output register and the
// downstream tready. No input transaction is taken from the compute until its last result
// has entered the output register. Results carry the offset, the minimal deletion count
// (zero when unreachable) and a reachable flag; tlast marks the final offset. After the last
// result both symbol counts are cleared. The user must write the deletion limit register
// through the cfg channel only while the block is idle; the block itself does not enforce this.
`default_nettype none

module deletion_edit_cost_row
  import dec_pkg::*;
#(
  parameter int unsigned MAX_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [5:0]  cfg_data_i,    // deletion limit[5:0]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // symbol[7:0]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // offset[5:0], deletions[11:6], reachable[12], zero[15:13]
  output logic        m_axis_tlast
);

  dec_cmd_t   cmd;
  dec_stat_t  stat;
  logic [5:0] out_offset;
  logic [5:0] out_del;
  logic       out_reach;

  assign cfg_ready_o = 1'b1;

  dec_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dec_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sym_i        (s_axis_tdata),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_offset_o (out_offset),
    .out_del_o    (out_del),
    .out_reach_o  (out_reach),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_reach, out_del, out_offset};

endmodule

`default_nettype wire

### hw/rtl/dec_checker.sv
// Port-level checker for the deletion-only edit cost row block, with its bind.
`default_nettype none

module dec_checker
  import dec_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // A compute transaction blocks the input for at least the following cycle.
  a_compute_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_COMPUTE)) |=> !s_axis_tready)
    else $error("input ready right after a compute transaction");

  // While results other than the last are pending, no input is taken.
  a_emit_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("input ready while a compute is still emitting");

  // An unreachable offset reports zero deletions and zero padding.
  a_unreach_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:13] == 3'b000) &&
                      (m_axis_tdata[12] || (m_axis_tdata[11:6] == 6'd0)))
    else $error("unreachable result with nonzero deletions or padding");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled result changed or dropped");

endmodule

bind deletion_edit_cost_row dec_checker u_dec_checker (.*);

`default_nettype wire

### dv/deletion_edit_cost_row_tb.sv
// Self-checking testbench for the deletion-only edit cost row block.
`timescale 1ns / 100ps

class cost_row_board;
  localparam int unsigned Depth = 32;

  typedef struct {
    logic [5:0] offset;
    logic [5:0] deletions;
    logic       reachable;
    logic       last;
  } cost_entry_t;

  logic [7:0]  win_sym [Depth];
  logic [7:0]  pat_sym [Depth];
  int unsigned win_len;
  int unsigned pat_len;
  int unsigned deletion_limit;
  cost_entry_t pending_costs [$];
  int unsigned failures;

  function new();
    win_len = 0;
    pat_len = 0;
    deletion_limit = 32;
    failures = 0;
  endfunction

  function void set_limit(logic [5:0] value);
    deletion_limit = value;
  endfunction

  function int unsigned pending_count();
    return pending_costs.size();
  endfunction

  // Loads add a symbol; a compute runs the deletion-only recurrence, one entry per offset.
  function void absorb_item(logic [1:0] op, logic [7:0] sym);
    int unsigned span;
    int unsigned lim;
    int unsigned u;
    int unsigned o;
    int unsigned cost [Depth+1];
    int unsigned nxt [Depth+1];
    bit ok [Depth+1];
    bit nok [Depth+1];
    cost_entry_t e;
    case (op)
      dec_pkg::OP_LOAD_WINDOW: begin
        if (win_len < Depth) begin
          win_sym[win_len] = sym;
          win_len++;
        end
      end
      dec_pkg::OP_LOAD_PATTERN: begin
        if (pat_len < Depth) begin
          pat_sym[pat_len] = sym;
          pat_len++;
        end
      end
      dec_pkg::OP_COMPUTE: begin
        span = ((pat_len < win_len) ? pat_len : win_len) + 1;
        for (o = 0; o < span; o++) begin
          cost[o] = 0;
          ok[o] = 1'b0;
        end
        ok[0] = 1'b1;
        for (u = 0; u < pat_len; u++) begin
          lim = (u + 2 < span) ? u + 2 : span;
          for (o = 0; o < span; o++) begin
            nxt[o] = 0;
            nok[o] = 1'b0;
          end
          if (ok[0] && cost[0] + 1 <= deletion_limit) begin
            nxt[0] = cost[0] + 1;
            nok[0] = 1'b1;
          end
          for (o = 1; o < lim; o++) begin
            if (pat_sym[u] == win_sym[o-1] && ok[o-1]) begin
              nxt[o] = cost[o-1];
              nok[o] = 1'b1;
            end
            if (ok[o] && cost[o] + 1 <= deletion_limit) begin
              if (!nok[o] || cost[o] + 1 < nxt[o]) begin
                nxt[o] = cost[o] + 1;
                nok[o] = 1'b1;
              end
            end
          end
          for (o = 0; o < span; o++) begin
            cost[o] = nxt[o];
            ok[o] = nok[o];
          end
        end
        for (o = 0; o < span; o++) begin
          e.offset = 6'(o);
          e.deletions = ok[o] ? 6'(cost[o]) : 6'd0;
          e.reachable = ok[o];
          e.last = (o + 1 == span);
          pending_costs.push_back(e);
        end
        win_len = 0;
        pat_len = 0;
      end
      default: begin
      end
    endcase
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failures++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_cost(logic [15:0] word, logic tlast);
    cost_entry_t e;
    if (pending_costs.size() == 0) begin
      failures++;
      $display("%0t: unexpected result, expected none, actual tdata=%h tlast=%b",
               $time, word, tlast);
      return;
    end
    e = pending_costs.pop_front();
    compare_field("offset", e.offset, word[5:0]);
    compare_field("deletions", e.deletions, word[11:6]);
    compare_field("reachable", e.reachable, word[12]);
    compare_field("padding", 0, word[15:13]);
    compare_field("tlast", e.last, tlast);
  endfunction
endclass

module deletion_edit_cost_row_tb;
  import dec_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned PhaseItems = 25;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [5:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // symbol[7:0]
  logic [1:0]  s_axis_tuser = '0;   // operation[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // offset[5:0], deletions[11:6], reachable[12]
  logic        m_axis_tlast;

  cost_row_board board = new();

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned items_sent = 0;
  logic [7:0]  alphabet [3];

  deletion_edit_cost_row uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  always @(negedge clk_i) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = LongHoldCycles;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      board.check_cost(m_axis_tdata, m_axis_tlast);
    end
  end

  task automatic send_item(input logic [1:0] op, input logic [7:0] sym);
    int unsigned gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= sym;
    do @(posedge clk_i); while (!s_axis_tready);
    board.absorb_item(op, sym);
    if (op != OP_UNUSED) items_sent++;
  endtask

  task automatic drain_and_settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [5:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_limit(value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(4) == 0) return 8'($urandom);
    return alphabet[$urandom_range(2)];
  endfunction

  // One window and one pattern, loaded in an interleaved order, mostly closed by a compute.
  task automatic send_run();
    logic [7:0] win [$];
    logic [7:0] pat [$];
    int unsigned wlen;
    int unsigned wi;
    int unsigned pj;
    int unsigned k;
    foreach (alphabet[i]) alphabet[i] = 8'($urandom);
    wlen = ($urandom_range(9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
    for (k = 0; k < wlen; k++) win.push_back(pick_symbol());
    if ($urandom_range(9) < 7) begin
      foreach (win[i]) begin
        while ($urandom_range(3) == 0) pat.push_back(pick_symbol());
        if ($urandom_range(9) != 0) pat.push_back(win[i]);
      end
    end else begin
      repeat ($urandom_range(0, wlen + 3)) pat.push_back(pick_symbol());
    end
    wi = 0;
    pj = 0;
    while (wi < win.size() || pj < pat.size()) begin
      if ($urandom_range(19) == 0) send_item(OP_UNUSED, 8'($urandom));
      if (pj >= pat.size() || (wi < win.size() && $urandom_range(1) == 1)) begin
        send_item(OP_LOAD_WINDOW, win[wi]);
        wi++;
      end else begin
        send_item(OP_LOAD_PATTERN, pat[pj]);
        pj++;
      end
    end
    if ($urandom_range(19) != 0) send_item(OP_COMPUTE, 8'($urandom));
  endtask

  task automatic send_directed();
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_UNUSED, 8'hA5);
    send_item(OP_LOAD_WINDOW, 8'h00);
    send_item(OP_LOAD_WINDOW, 8'hFF);
    send_item(OP_LOAD_PATTERN, 8'h00);
    send_item(OP_LOAD_PATTERN, 8'h7E);
    send_item(OP_LOAD_PATTERN, 8'hFF);
    send_item(OP_COMPUTE, 8'hFF);
    send_item(OP_LOAD_PATTERN, 8'h55);
    send_item(OP_COMPUTE, 8'h5A);
    send_item(OP_LOAD_WINDOW, 8'hAA);
    send_item(OP_COMPUTE, 8'h01);
    send_item(OP_LOAD_WINDOW, 8'h3C);
    send_item(OP_LOAD_WINDOW, 8'h3C);
    send_item(OP_LOAD_PATTERN, 8'h3C);
    send_item(OP_LOAD_PATTERN, 8'hC3);
    send_item(OP_LOAD_PATTERN, 8'h3C);
    send_item(OP_COMPUTE, 8'h80);
  endtask

  initial begin
    int unsigned phase;
    int unsigned target;
    logic [5:0] limit;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      drain_and_settle();
      case (phase)
        0: begin limit = 6'd32; send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin limit = 6'd0; send_idle_pct = 63; recv_stall_pct = 0; end
        2: begin limit = 6'd1; send_idle_pct = 0; recv_stall_pct = 63; end
        3: begin limit = 6'($urandom_range(2, 31)); send_idle_pct = 30; recv_stall_pct = 30; end
        4: begin limit = 6'd32; send_idle_pct = 0; recv_stall_pct = 0; end
        default: begin
          limit = 6'($urandom_range(0, 32));
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      write_limit(limit);
      if (phase == 0) send_directed();
      if (phase == 4) begin
        @(posedge clk_i);
        hold_requests++;
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        send_run();
        if ($urandom_range(7) == 0) drain_and_settle();
      end
    end
    drain_and_settle();
    repeat (40) @(posedge clk_i);
    if (board.failures == 0 && board.pending_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
